[rtl/lrast_pkg.sv]
package lrast_pkg;

  localparam int ADDR_W     = 28;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STRIDE_W   = 16;
  localparam int BPP_W      = 4;
  localparam int ANGLE_W    = 9;

  localparam logic [ADDR_W-1:0]   ADDR_MAX   = {ADDR_W{1'b1}};
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd16384;
  localparam logic [BPP_W-1:0]    BPP_RST    = 4'd4;
  localparam logic [ANGLE_W-1:0]  ANGLE_GOD  = 9'd240;
  localparam logic [ANGLE_W-1:0]  ANGLE_BLUE = 9'd180;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOD_MODE        = 2'd0,
    CFG_VIEW_ANGLE      = 2'd1,
    CFG_LINE_STRIDE     = 2'd2,
    CFG_BYTES_PER_PIXEL = 2'd3
  } cfg_idx_t;

  // Sequencer states of the rasterizer
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL_Y = 6'b001000,
    S_MUL_X = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

endpackage

[rtl/lrast_div.sv]
module lrast_div #(
  parameter int DIV_W = 12,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  // Computes (dividend << (Q_W-1)) / divisor, one quotient bit a cycle.
  // Valid when dividend <= divisor, so the quotient fits in Q_W bits.
  localparam int CNT_W = $clog2(Q_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   num_r, num_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, num_r[Q_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = DIV_W'(dividend >> 1);
      num_nxt  = {dividend[0], (Q_W-1)'(0)};
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      num_nxt = num_r << 1;
      quo_nxt = {quo_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(Q_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/antialiased_line_rasterizer.sv]
// Anti-aliased line rasterizer, Wu style.
// Input stream: in_tuser is the mode (0 = start a line, 1 = advance one column);
// in_tdata carries start_x, start_y, end_x, end_y, used on a start request.
// Output stream: one request per pixel write with x, y, byte address and the
// three colour bytes scaled by the pixel weight; out_tlast marks the final
// write of the line. Configuration writes go through cfg_we/cfg_index/cfg_wdata
// and take effect at once; change them only while no line work is pending.
// Sequence: a start request orders its endpoints in a setup step, runs the
// bit-serial slope divider and then makes one write per endpoint; an advance
// request makes one write, or two when the row fraction is not zero.
// Each write goes through the shared multiplier twice (row * stride, then
// column * bytes per pixel) and a load step into the output register.
// An advance with no active line is taken and gives nothing.
// in_tready is high only while the sequencer is idle.
// The output register decouples the two sides: a stalled receiver holds the
// current write while the block may take the next request; the sequencer
// waits in its load step until the output register is free.
// Reset clears the line state and restores the configuration defaults
// (stride 16384, 4 bytes per pixel, white colour).
module antialiased_line_rasterizer #(
  parameter  int COORD_BITS = 12,
  parameter  int FRAC_BITS  = 16,
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((2 * (COORD_BITS + 1) + lrast_pkg::ADDR_W
                               + 3 * lrast_pkg::CHAN_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DATA_W-1:0]             in_tdata,   // start_x, start_y, end_x, end_y
  input  logic                             in_tuser,   // mode
  input  logic                             cfg_we,
  input  logic [lrast_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrast_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_DATA_W-1:0]            out_tdata,  // pixel_x, pixel_y, byte_address,
                                                       // chan0, chan1, chan2
  output logic                             out_tlast
);

  import lrast_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int PW     = COORD_BITS + 1;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int SL_W   = FRAC_BITS + 2;
  localparam int RA_W   = COORD_BITS + FRAC_BITS + 2;
  localparam int PROD_W = PW + STRIDE_W;
  localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W + 1;
  localparam logic [W_W-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  state_t state_r, state_nxt;

  logic                   god_r, god_nxt;
  logic [ANGLE_W-1:0]     angle_r, angle_nxt;
  logic [STRIDE_W-1:0]    stride_r, stride_nxt;
  logic [BPP_W-1:0]       bpp_r, bpp_nxt;
  logic                   line_active_r, line_active_nxt;
  logic                   have_pend_r, have_pend_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   swap_r, swap_nxt;
  logic [CB-1:0]          a_maj_r, a_maj_nxt;
  logic [CB-1:0]          a_min_r, a_min_nxt;
  logic [CB-1:0]          b_maj_r, b_maj_nxt;
  logic [CB-1:0]          b_min_r, b_min_nxt;
  logic                   dy_neg_r, dy_neg_nxt;
  logic                   dx_zero_r, dx_zero_nxt;
  logic [PW-1:0]          col_now_r, col_now_nxt;
  logic [CB-1:0]          col_end_r, col_end_nxt;
  logic signed [SL_W-1:0] slope_r, slope_nxt;
  logic signed [RA_W-1:0] row_acc_r, row_acc_nxt;
  logic [PW-1:0]          cur_maj_r, cur_maj_nxt;
  logic [PW-1:0]          cur_min_r, cur_min_nxt;
  logic [W_W-1:0]         cur_w_r, cur_w_nxt;
  logic                   cur_last_r, cur_last_nxt;
  logic [PW-1:0]          pend_maj_r, pend_maj_nxt;
  logic [PW-1:0]          pend_min_r, pend_min_nxt;
  logic [W_W-1:0]         pend_w_r, pend_w_nxt;
  logic                   pend_last_r, pend_last_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [PW-1:0]          out_px_r, out_px_nxt;
  logic [PW-1:0]          out_py_r, out_py_nxt;
  logic [ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  logic [CHAN_W-1:0]      out_c0_r, out_c0_nxt;
  logic [CHAN_W-1:0]      out_c1_r, out_c1_nxt;
  logic [CHAN_W-1:0]      out_c2_r, out_c2_nxt;
  logic                   out_last_r, out_last_nxt;

  // Input fields and start setup
  logic [CB-1:0] in_sx, in_sy, in_ex, in_ey;
  logic [CB-1:0] adx, ady;
  logic          steep;

  // Ordering and divider
  logic          order_flip;
  logic [CB-1:0] lo_maj, lo_min, hi_maj, hi_min;
  logic [CB-1:0] dx, ady_o;
  logic          div_start, div_done;
  logic [W_W-1:0]  div_quo;
  logic signed [SL_W-1:0] slope_mag;

  // Column stepping
  logic [RA_W-1:0]      acc_pos;
  logic [FRAC_BITS-1:0] frac;
  logic [PW-1:0]        row;
  logic                 frac_zero;
  logic                 final_col;

  // Shared multiplier and pixel formatting
  logic [PW-1:0]       px_cur, py_cur;
  logic [PW-1:0]       mul_a;
  logic [STRIDE_W-1:0] mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [W_W+7:0]      s_ff_full;
  logic [W_W+4:0]      s_1a_full;
  logic [CHAN_W-1:0]   s_ff, s_1a;
  logic                orange, blue;
  logic                load;

  assign in_sx = in_tdata[CB-1:0];
  assign in_sy = in_tdata[2*CB-1:CB];
  assign in_ex = in_tdata[3*CB-1:2*CB];
  assign in_ey = in_tdata[4*CB-1:3*CB];
  assign adx   = (in_ex > in_sx) ? in_ex - in_sx : in_sx - in_ex;
  assign ady   = (in_ey > in_sy) ? in_ey - in_sy : in_sy - in_ey;
  assign steep = ady > adx;

  assign order_flip = a_maj_r > b_maj_r;
  assign lo_maj = order_flip ? b_maj_r : a_maj_r;
  assign lo_min = order_flip ? b_min_r : a_min_r;
  assign hi_maj = order_flip ? a_maj_r : b_maj_r;
  assign hi_min = order_flip ? a_min_r : b_min_r;
  assign dx     = hi_maj - lo_maj;
  assign ady_o  = (lo_min > hi_min) ? lo_min - hi_min : hi_min - lo_min;

  assign div_start = (state_r == S_PREP);
  assign slope_mag = SL_W'(div_quo);

  lrast_div #(
    .DIV_W (CB),
    .Q_W   (W_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ady_o),
    .divisor  (dx),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign acc_pos   = row_acc_r[RA_W-1] ? '0 : row_acc_r;
  assign frac      = acc_pos[FRAC_BITS-1:0];
  assign row       = acc_pos[FRAC_BITS +: PW];
  assign frac_zero = (frac == '0);
  assign final_col = col_now_r >= {1'b0, col_end_r};

  assign px_cur = swap_r ? cur_min_r : cur_maj_r;
  assign py_cur = swap_r ? cur_maj_r : cur_min_r;
  assign mul_a  = (state_r == S_MUL_Y) ? py_cur : px_cur;
  assign mul_b  = (state_r == S_MUL_Y) ? stride_r : STRIDE_W'(bpp_r);
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Weight times 0xFF and 0x1A as shift-and-add
  assign s_ff_full = {cur_w_r, 8'd0} - (W_W+8)'(cur_w_r);
  assign s_1a_full = (W_W+5)'({cur_w_r, 4'd0}) + (W_W+5)'({cur_w_r, 3'd0})
                   + (W_W+5)'({cur_w_r, 1'd0});
  assign s_ff = s_ff_full[FRAC_BITS +: CHAN_W];
  assign s_1a = s_1a_full[FRAC_BITS +: CHAN_W];

  assign orange = god_r && (angle_r > ANGLE_GOD);
  assign blue   = !orange && (angle_r >= ANGLE_BLUE);
  assign load   = (state_r == S_LOAD) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt       = state_r;
    god_nxt         = god_r;
    angle_nxt       = angle_r;
    stride_nxt      = stride_r;
    bpp_nxt         = bpp_r;
    line_active_nxt = line_active_r;
    have_pend_nxt   = have_pend_r;
    out_valid_nxt   = out_valid_r;
    swap_nxt        = swap_r;
    a_maj_nxt       = a_maj_r;
    a_min_nxt       = a_min_r;
    b_maj_nxt       = b_maj_r;
    b_min_nxt       = b_min_r;
    dy_neg_nxt      = dy_neg_r;
    dx_zero_nxt     = dx_zero_r;
    col_now_nxt     = col_now_r;
    col_end_nxt     = col_end_r;
    slope_nxt       = slope_r;
    row_acc_nxt     = row_acc_r;
    cur_maj_nxt     = cur_maj_r;
    cur_min_nxt     = cur_min_r;
    cur_w_nxt       = cur_w_r;
    cur_last_nxt    = cur_last_r;
    pend_maj_nxt    = pend_maj_r;
    pend_min_nxt    = pend_min_r;
    pend_w_nxt      = pend_w_r;
    pend_last_nxt   = pend_last_r;
    prod_nxt        = prod_r;
    sum_nxt         = sum_r;
    out_px_nxt      = out_px_r;
    out_py_nxt      = out_py_r;
    out_addr_nxt    = out_addr_r;
    out_c0_nxt      = out_c0_r;
    out_c1_nxt      = out_c1_r;
    out_c2_nxt      = out_c2_r;
    out_last_nxt    = out_last_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GOD_MODE:        god_nxt    = cfg_wdata[0];
        CFG_VIEW_ANGLE:      angle_nxt  = cfg_wdata[ANGLE_W-1:0];
        CFG_LINE_STRIDE:     stride_nxt = cfg_wdata[STRIDE_W-1:0];
        CFG_BYTES_PER_PIXEL: bpp_nxt    = cfg_wdata[BPP_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!in_tuser) begin
            swap_nxt  = steep;
            a_maj_nxt = steep ? in_sy : in_sx;
            a_min_nxt = steep ? in_sx : in_sy;
            b_maj_nxt = steep ? in_ey : in_ex;
            b_min_nxt = steep ? in_ex : in_ey;
            state_nxt = S_PREP;
          end else if (line_active_r) begin
            cur_maj_nxt   = col_now_r;
            cur_min_nxt   = row;
            cur_w_nxt     = ONE_W - W_W'(frac);
            cur_last_nxt  = final_col && frac_zero;
            pend_maj_nxt  = col_now_r;
            pend_min_nxt  = row + 1'b1;
            pend_w_nxt    = W_W'(frac);
            pend_last_nxt = final_col;
            have_pend_nxt = !frac_zero;
            row_acc_nxt   = row_acc_r + RA_W'(slope_r);
            col_now_nxt   = col_now_r + 1'b1;
            if (final_col) begin
              line_active_nxt = 1'b0;
            end
            state_nxt = S_MUL_Y;
          end
        end
      end
      S_PREP: begin
        // Order endpoints by the major axis; the divider starts this cycle
        a_maj_nxt   = lo_maj;
        a_min_nxt   = lo_min;
        b_maj_nxt   = hi_maj;
        b_min_nxt   = hi_min;
        dy_neg_nxt  = lo_min > hi_min;
        dx_zero_nxt = (dx == '0);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (dx_zero_r) begin
            slope_nxt = '0;
          end else begin
            slope_nxt = dy_neg_r ? -slope_mag : slope_mag;
          end
          row_acc_nxt     = $signed({2'b00, a_min_r, {FRAC_BITS{1'b0}}})
                          + RA_W'(slope_nxt);
          col_now_nxt     = {1'b0, a_maj_r} + 1'b1;
          col_end_nxt     = b_maj_r;
          line_active_nxt = !dx_zero_r;
          cur_maj_nxt     = {1'b0, a_maj_r};
          cur_min_nxt     = {1'b0, a_min_r};
          cur_w_nxt       = ONE_W;
          cur_last_nxt    = 1'b0;
          pend_maj_nxt    = {1'b0, b_maj_r};
          pend_min_nxt    = {1'b0, b_min_r};
          pend_w_nxt      = ONE_W;
          pend_last_nxt   = dx_zero_r;
          have_pend_nxt   = 1'b1;
          state_nxt       = S_MUL_Y;
        end
      end
      S_MUL_Y: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL_X;
      end
      S_MUL_X: begin
        sum_nxt   = SUM_W'(prod_r) + SUM_W'(mul_p);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // Hold here until the output register is free
        if (load) begin
          out_valid_nxt = 1'b1;
          out_px_nxt    = px_cur;
          out_py_nxt    = py_cur;
          out_addr_nxt  = (sum_r > SUM_W'(ADDR_MAX)) ? ADDR_MAX : sum_r[ADDR_W-1:0];
          out_c0_nxt    = blue ? '0 : s_ff;
          out_c1_nxt    = orange ? s_1a : (blue ? '0 : s_ff);
          out_c2_nxt    = orange ? '0 : s_ff;
          out_last_nxt  = cur_last_r;
          if (have_pend_r) begin
            cur_maj_nxt   = pend_maj_r;
            cur_min_nxt   = pend_min_r;
            cur_w_nxt     = pend_w_r;
            cur_last_nxt  = pend_last_r;
            have_pend_nxt = 1'b0;
            state_nxt     = S_MUL_Y;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      god_r         <= 1'b0;
      angle_r       <= '0;
      stride_r      <= STRIDE_RST;
      bpp_r         <= BPP_RST;
      line_active_r <= 1'b0;
      have_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      god_r         <= god_nxt;
      angle_r       <= angle_nxt;
      stride_r      <= stride_nxt;
      bpp_r         <= bpp_nxt;
      line_active_r <= line_active_nxt;
      have_pend_r   <= have_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    swap_r      <= swap_nxt;
    a_maj_r     <= a_maj_nxt;
    a_min_r     <= a_min_nxt;
    b_maj_r     <= b_maj_nxt;
    b_min_r     <= b_min_nxt;
    dy_neg_r    <= dy_neg_nxt;
    dx_zero_r   <= dx_zero_nxt;
    col_now_r   <= col_now_nxt;
    col_end_r   <= col_end_nxt;
    slope_r     <= slope_nxt;
    row_acc_r   <= row_acc_nxt;
    cur_maj_r   <= cur_maj_nxt;
    cur_min_r   <= cur_min_nxt;
    cur_w_r     <= cur_w_nxt;
    cur_last_r  <= cur_last_nxt;
    pend_maj_r  <= pend_maj_nxt;
    pend_min_r  <= pend_min_nxt;
    pend_w_r    <= pend_w_nxt;
    pend_last_r <= pend_last_nxt;
    prod_r      <= prod_nxt;
    sum_r       <= sum_nxt;
    out_px_r    <= out_px_nxt;
    out_py_r    <= out_py_nxt;
    out_addr_r  <= out_addr_nxt;
    out_c0_r    <= out_c0_nxt;
    out_c1_r    <= out_c1_nxt;
    out_c2_r    <= out_c2_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'({out_c2_r, out_c1_r, out_c0_r, out_addr_r,
                                   out_py_r, out_px_r});

endmodule

[rtl/lrast_chk.sv]
module lrast_chk #(
  parameter int DATA_W = 80
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tlast
);

  // Reset leaves the block idle with no pending write
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // A start request always occupies the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("start request did not occupy the sequencer");

  // A new write only appears out of sequencer work
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("write appeared while the sequencer was idle");

  // Stalled write holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled write changed");

endmodule

bind antialiased_line_rasterizer lrast_chk #(.DATA_W(OUT_DATA_W)) u_lrast_chk (.*);

[sim/antialiased_line_rasterizer_test.sv]
`timescale 1ns / 100ps

module antialiased_line_rasterizer_test;
  import lrast_pkg::*;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 16;
  localparam int IN_W          = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W         = ((2 * (COORD_BITS + 1) + ADDR_W + 3 * CHAN_W + 7) / 8) * 8;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam longint ONE_FIXED = longint'(1) << FRAC_BITS;
  localparam longint ADDR_TOP  = longint'(ADDR_MAX);

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = FRAC_BITS + 16;
  localparam int RX_LONG_HOLD  = 400;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int NUM_PHASES    = 7;
  localparam int MAX_REPORTS   = 200;
  localparam int TIMEOUT_NS    = 4_000_000;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  localparam logic [CHAN_W-1:0] BYTE_FULL    = 8'hFF;
  localparam logic [CHAN_W-1:0] BYTE_NONE    = 8'h00;
  localparam logic [CHAN_W-1:0] ORANGE_GREEN = 8'h1A;

  typedef struct packed {
    logic [12:0]       x;
    logic [12:0]       y;
    logic [ADDR_W-1:0] addr;
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    logic              last;
  } pixel_t;

  // typed rows carry their results, the others go through the predictor
  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic                  typed;
    logic [1:0]            n_typed;
    pixel_t                p0;
    pixel_t                p1;
  } step_row_t;

  localparam pixel_t NO_PIXEL    = '0;
  localparam pixel_t ORIGIN      = '{13'd0, 13'd0, 28'd0, BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b0};
  localparam pixel_t ORIGIN_LAST = '{13'd0, 13'd0, 28'd0, BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b1};
  localparam pixel_t CORNER      = '{13'd4095, 13'd4095, 28'd67108860,
                                     BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b0};
  localparam pixel_t CORNER_LAST = '{13'd4095, 13'd4095, 28'd67108860,
                                     BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b1};
  localparam pixel_t COL1        = '{13'd1, 13'd0, 28'd4, BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b0};
  localparam pixel_t COL2        = '{13'd2, 13'd0, 28'd8, BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b0};
  localparam pixel_t COL3        = '{13'd3, 13'd0, 28'd12, BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b0};
  localparam pixel_t COL3_LAST   = '{13'd3, 13'd0, 28'd12, BYTE_FULL, BYTE_FULL, BYTE_FULL, 1'b1};

  localparam step_row_t DIRECTED [24] = '{
    // coincident endpoints at both corners of the screen
    '{MODE_START,   12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd2, ORIGIN, ORIGIN_LAST},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_START,   12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 2'd2, CORNER, CORNER_LAST},
    '{MODE_ADVANCE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 2'd0, NO_PIXEL, NO_PIXEL},
    // flat line: zero fraction, upper pixel skipped, end column repeated
    '{MODE_START,   12'd0,    12'd0,    12'd3,    12'd0,    1'b1, 2'd2, ORIGIN, COL3},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd1, COL1, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd1, COL2, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd1, COL3_LAST, NO_PIXEL},
    '{MODE_ADVANCE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 2'd0, NO_PIXEL, NO_PIXEL},
    // shallow line with fractional rows
    '{MODE_START,   12'd0,    12'd0,    12'd3,    12'd1,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    // steep line, then dropped by a start with reversed endpoints
    '{MODE_START,   12'd10,   12'd20,   12'd13,   12'd100,  1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_START,   12'd100,  12'd5,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    // full-screen diagonal with negative slope
    '{MODE_START,   12'd0,    12'd4095, 12'd4095, 12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    // equal |dx| and |dy| stays unswapped
    '{MODE_START,   12'd2,    12'd2,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL},
    '{MODE_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, NO_PIXEL, NO_PIXEL}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tlast;

  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit rx_long_hold = 1'b0;
  int fail_count   = 0;

  pixel_t pixels_due[$];

  // predictor state and its copy of the registers
  logic               god_mode    = 1'b0;
  logic [ANGLE_W-1:0] view_angle  = '0;
  logic [STRIDE_W-1:0] line_stride = STRIDE_RST;
  logic [BPP_W-1:0]   pixel_bytes = BPP_RST;
  logic               line_on     = 1'b0;
  logic               swapped     = 1'b0;
  logic [12:0]        col_now     = '0;
  logic [11:0]        col_end     = '0;
  longint             slope       = 0;
  longint             row_acc     = 0;
  pixel_t             step_pix [2];
  int                 step_cnt;

  antialiased_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // endpoint within span of c, reflected back onto the screen
  function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] c,
                                                        input int span);
    int d;
    int v;
    d = $urandom_range(0, span);
    v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
    if (v > COORD_MAX || v < 0) v = 2 * int'(c) - v;
    return COORD_BITS'(v);
  endfunction

  function automatic string pixel_text(input pixel_t p);
    return $sformatf("x=%0d y=%0d addr=0x%07h rgb=%02h%02h%02h last=%b",
                     p.x, p.y, p.addr, p.c0, p.c1, p.c2, p.last);
  endfunction

  function automatic void add_pixel(input longint major, input longint minor,
                                    input longint weight, input logic last);
    longint            px;
    longint            py;
    longint            addr;
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    pixel_t            p;
    px = swapped ? minor : major;
    py = swapped ? major : minor;
    addr = py * longint'(line_stride) + px * longint'(pixel_bytes);
    if (addr > ADDR_TOP) addr = ADDR_TOP;
    if (god_mode && view_angle > ANGLE_GOD) begin
      c0 = BYTE_FULL; c1 = ORANGE_GREEN; c2 = BYTE_NONE;
    end else if (view_angle >= ANGLE_BLUE) begin
      c0 = BYTE_NONE; c1 = BYTE_NONE; c2 = BYTE_FULL;
    end else begin
      c0 = BYTE_FULL; c1 = BYTE_FULL; c2 = BYTE_FULL;
    end
    p.x    = px[12:0];
    p.y    = py[12:0];
    p.addr = addr[ADDR_W-1:0];
    p.c0   = CHAN_W'((longint'(c0) * weight) >> FRAC_BITS);
    p.c1   = CHAN_W'((longint'(c1) * weight) >> FRAC_BITS);
    p.c2   = CHAN_W'((longint'(c2) * weight) >> FRAC_BITS);
    p.last = last;
    step_pix[step_cnt] = p;
    step_cnt++;
  endfunction

  // advance the line state by one request and leave its pixel writes in step_pix
  function automatic void rasterize_step(input step_row_t req);
    longint ax, ay, bx, by, t, dx, dy, adx, ady, mag;
    longint acc, frac, row_idx;
    logic   final_col;
    step_cnt = 0;
    if (req.mode == MODE_START) begin
      ax = req.sx; ay = req.sy; bx = req.ex; by = req.ey;
      adx = bx > ax ? bx - ax : ax - bx;
      ady = by > ay ? by - ay : ay - by;
      swapped = ady > adx;
      if (swapped) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      if (dx == 0) begin
        slope = 0;
      end else begin
        mag = ((dy < 0 ? -dy : dy) << FRAC_BITS) / dx;
        slope = dy < 0 ? -mag : mag;
      end
      row_acc = ay * ONE_FIXED + slope;
      col_now = 13'(ax + 1);
      col_end = 12'(bx);
      line_on = dx > 0;
      add_pixel(ax, ay, ONE_FIXED, 1'b0);
      add_pixel(bx, by, ONE_FIXED, !line_on);
    end else if (line_on) begin
      acc = row_acc < 0 ? 0 : row_acc;
      frac = acc & (ONE_FIXED - 1);
      row_idx = acc >> FRAC_BITS;
      final_col = col_now >= {1'b0, col_end};
      add_pixel(longint'(col_now), row_idx, ONE_FIXED - frac, final_col && frac == 0);
      if (frac != 0) add_pixel(longint'(col_now), row_idx + 1, frac, final_col);
      row_acc += slope;
      col_now = col_now + 13'd1;
      if (final_col) line_on = 1'b0;
    end
  endfunction

  task automatic send_request(input step_row_t req, output int n);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.mode;
    in_tdata  <= IN_W'({req.ey, req.ex, req.sy, req.sx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rasterize_step(req);
    if (req.typed) begin
      n = req.n_typed;
      if (n > 0) pixels_due.push_back(req.p0);
      if (n > 1) pixels_due.push_back(req.p1);
    end else begin
      n = step_cnt;
      for (int k = 0; k < step_cnt; k++) pixels_due.push_back(step_pix[k]);
    end
  endtask

  // drop valid and hold until every pixel write has come back
  task automatic wait_idle(input bit settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_due.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_GOD_MODE:        god_mode    = value[0];
      CFG_VIEW_ANGLE:      view_angle  = value[ANGLE_W-1:0];
      CFG_LINE_STRIDE:     line_stride = value[STRIDE_W-1:0];
      CFG_BYTES_PER_PIXEL: pixel_bytes = value[BPP_W-1:0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    step_row_t           req;
    int                  got, useful, kind, cols, n_adv, span;
    logic                god_v;
    logic [ANGLE_W-1:0]  angle_v;
    logic [STRIDE_W-1:0] stride_v;
    logic [BPP_W-1:0]    bpp_v;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_request(DIRECTED[i], got);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle(1'b1);
      stride_v = STRIDE_W'($urandom);
      bpp_v    = BPP_W'($urandom_range(1, 8));
      case (ph)
        0: begin god_v = 1'b1; angle_v = 9'd359; stride_v = '1;       bpp_v = 4'd8; end
        1: begin god_v = 1'b0; angle_v = 9'd0;   stride_v = '0;       bpp_v = 4'd1; end
        2: begin god_v = 1'b1; angle_v = ANGLE_GOD; stride_v = 16'd4096; bpp_v = 4'd3; end
        3: begin god_v = 1'b1; angle_v = ANGLE_GOD + 9'd1; end
        4: begin god_v = 1'b0; angle_v = ANGLE_BLUE; end
        5: begin god_v = 1'b1; angle_v = ANGLE_BLUE - 9'd1; end
        default: begin
          god_v   = 1'($urandom);
          angle_v = ANGLE_W'($urandom_range(0, 359));
        end
      endcase
      write_reg(CFG_GOD_MODE, CFG_DATA_W'(god_v));
      write_reg(CFG_VIEW_ANGLE, CFG_DATA_W'(angle_v));
      write_reg(CFG_LINE_STRIDE, CFG_DATA_W'(stride_v));
      write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp_v));
      cfg_we <= 1'b0;
      tx_idle_on = (ph != 0);
      rx_idle_on = (ph != 0);
      // stall the sink long enough to back the block up into its input
      if (ph == 2) rx_long_hold = 1'b1;

      useful = 0;
      while (useful < RANDOM_ITEMS / NUM_PHASES) begin
        kind = $urandom_range(0, 19);
        req = '0;
        if (kind == 0) begin
          // stray advance: continues the current line or is dropped
          req.mode = MODE_ADVANCE;
          req.sx = COORD_BITS'($urandom); req.sy = COORD_BITS'($urandom);
          req.ex = COORD_BITS'($urandom); req.ey = COORD_BITS'($urandom);
          send_request(req, got);
          if (got > 0) useful++;
        end else begin
          req.mode = MODE_START;
          req.sx = pick_coord();
          req.sy = pick_coord();
          if (kind == 1) begin
            req.ex = pick_coord();
            req.ey = pick_coord();
          end else if (kind == 2) begin
            req.ex = req.sx;
            req.ey = req.sy;
          end else begin
            span = ($urandom_range(0, 9) == 0) ? 60 : 12;
            req.ex = near_coord(req.sx, span);
            req.ey = near_coord(req.sy, span);
          end
          send_request(req, got);
          useful++;
          cols = line_on ? int'(col_end) - int'(col_now) + 1 : 0;
          if (kind == 3 || cols > 64) n_adv = $urandom_range(0, (cols > 64) ? 64 : cols);
          else n_adv = cols + (($urandom_range(0, 4) == 0) ? 1 : 0);
          repeat (n_adv) begin
            req.mode = MODE_ADVANCE;
            req.sx = COORD_BITS'($urandom); req.sy = COORD_BITS'($urandom);
            req.ex = COORD_BITS'($urandom); req.ey = COORD_BITS'($urandom);
            send_request(req, got);
            if (got > 0) useful++;
          end
        end
        if ($urandom_range(0, 99) == 0) wait_idle(1'b0);
      end
    end

    wait_idle(1'b1);
    if (fail_count == 0 && pixels_due.size() == 0) begin
      $display("antialiased_line_rasterizer regression: pass");
    end else begin
      $display("antialiased_line_rasterizer regression: fail");
    end
    $finish;
  end

  initial begin : result_sink
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (rx_long_hold) begin
        out_tready <= 1'b0;
        repeat (RX_LONG_HOLD) @(posedge clk);
        rx_long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        gap_left = pick_gap() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t got;
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x    = out_tdata[12:0];
      got.y    = out_tdata[25:13];
      got.addr = out_tdata[53:26];
      got.c0   = out_tdata[61:54];
      got.c1   = out_tdata[69:62];
      got.c2   = out_tdata[77:70];
      got.last = out_tlast;
      if (pixels_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: unexpected pixel write, expected none, got %s",
                   $time, pixel_text(got));
      end else begin
        want = pixels_due.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: pixel mismatch, expected %s, got %s",
                     $time, pixel_text(want), pixel_text(got));
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("antialiased_line_rasterizer regression: fail");
    $finish;
  end

endmodule
